@@ hw/rtl/kcsg_pkg.sv @@
`default_nettype none

package kcsg_pkg;

  // Command classes written by the front end into the command queue.
  typedef enum logic [0:0] {
    CMD_ADVANCE = 1'b0,
    CMD_RESTART = 1'b1
  } cmd_t;

  // Configuration register indexes (word addresses).
  localparam logic [2:0] REG_START_X       = 3'd0;
  localparam logic [2:0] REG_START_Y       = 3'd1;
  localparam logic [2:0] REG_CURVE_LENGTH  = 3'd2;
  localparam logic [2:0] REG_CURVE_DEPTH   = 3'd3;
  localparam logic [2:0] REG_START_SEXTANT = 3'd4;

  // One emitted segment.
  typedef struct packed {
    logic [31:0] from_x;
    logic [31:0] from_y;
    logic [31:0] to_x;
    logic [31:0] to_y;
    logic        last;
  } result_t;

  // Request from the walker to the step setup unit.
  typedef struct packed {
    logic        start;
    logic [31:0] length;
    logic [3:0]  depth;
  } setup_req_t;

  // Response from the step setup unit.
  typedef struct packed {
    logic        done;
    logic [31:0] step_full;
    logic [31:0] step_height;
  } setup_rsp_t;

  typedef enum logic [1:0] {
    WK_READY,
    WK_SETUP,
    WK_FIRST
  } walk_state_t;

  typedef enum logic [2:0] {
    SU_IDLE,
    SU_DIV,
    SU_SQUARE,
    SU_TRIPLE,
    SU_ROOT,
    SU_DONE
  } setup_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/kcsg_fifo.sv @@
`default_nettype none

module kcsg_fifo #(
  parameter int W     = 1,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] wr_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rd_data,
  output logic              empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers wrap at the queue depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/kcsg_setup.sv @@
`default_nettype none

module kcsg_setup
  import kcsg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire setup_req_t req,
  output setup_rsp_t      rsp
);

  // Reciprocal of three: (n * THIRD_RECIP) >> 33 is floor(n / 3) for any 32-bit n.
  localparam logic [31:0] THIRD_RECIP = 32'hAAAA_AAAB;

  setup_state_t state;
  setup_state_t state_next;

  logic [4:0]  cnt;
  logic [31:0] quo;
  logic [63:0] third_prod;
  logic [63:0] prod;
  logic [63:0] rad;
  logic [63:0] root;
  logic [63:0] bitm;
  logic [63:0] root_sum;

  assign third_prod = {32'd0, quo} * {32'd0, THIRD_RECIP};
  assign root_sum   = root + bitm;

  // Next state. The walker only starts a setup for a nonzero depth, so the
  // divide counter never starts at zero.
  always_comb begin
    state_next = state;
    unique case (state)
      SU_IDLE:   if (req.start) state_next = SU_DIV;
      SU_DIV:    if (cnt == 5'd1) state_next = SU_SQUARE;
      SU_SQUARE: state_next = SU_TRIPLE;
      SU_TRIPLE: state_next = SU_ROOT;
      SU_ROOT:   if (cnt == 5'd31) state_next = SU_DONE;
      SU_DONE:   state_next = SU_IDLE;
      default:   state_next = SU_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    rsp.done        = (state == SU_DONE);
    rsp.step_full   = quo;
    rsp.step_height = 32'(root >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SU_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Divide by a power of three as one exact divide by three per depth
  // level, then square, triple and a one-bit-per-cycle integer square root.
  always_ff @(posedge clk) begin
    unique case (state)
      SU_IDLE: begin
        quo <= req.length;
        cnt <= {1'b0, req.depth};
      end
      SU_DIV: begin
        quo <= {1'b0, third_prod[63:33]};
        cnt <= cnt - 5'd1;
      end
      SU_SQUARE: begin
        prod <= {32'd0, quo} * {32'd0, quo};
      end
      SU_TRIPLE: begin
        rad  <= (prod << 1) + prod;
        root <= '0;
        bitm <= 64'h4000_0000_0000_0000;
        cnt  <= '0;
      end
      SU_ROOT: begin
        if (rad >= root_sum) begin
          rad  <= rad - root_sum;
          root <= (root >> 1) + bitm;
        end else begin
          root <= root >> 1;
        end
        bitm <= bitm >> 2;
        cnt  <= cnt + 5'd1;
      end
      SU_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/kcsg_walker.sv @@
`default_nettype none

module kcsg_walker
  import kcsg_pkg::*;
#(
  parameter int MAX_DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  input  wire cmd_t        cmd,
  output logic             cmd_pop,
  input  wire logic [31:0] cfg_start_x,
  input  wire logic [31:0] cfg_start_y,
  input  wire logic [31:0] cfg_length,
  input  wire logic [3:0]  cfg_depth,
  input  wire logic [2:0]  cfg_sextant,
  output setup_req_t       setup_req,
  input  wire setup_rsp_t  setup_rsp,
  input  wire logic        out_full,
  output logic             out_push,
  output result_t          out_data
);

  localparam int IDX_W = 2 * MAX_DEPTH;

  walk_state_t state;
  walk_state_t state_next;

  logic             running;
  logic [IDX_W-1:0] seg_idx;
  logic [IDX_W-1:0] total_m1;
  logic [2:0]       heading;
  logic [31:0]      pen_x;
  logic [31:0]      pen_y;
  logic [31:0]      step_full;
  logic [31:0]      step_height;

  logic [3:0]       depth_sat;
  logic [2:0]       sextant_mod;
  logic [IDX_W-1:0] mask;
  logic             is_restart;
  logic             do_restart;
  logic             emit;
  logic             last_seg;
  logic [31:0]      half;
  logic [31:0]      dx;
  logic [31:0]      dy;
  logic [31:0]      to_x;
  logic [31:0]      to_y;
  logic [1:0]       low_digit;
  logic [2:0]       delta;
  logic [3:0]       head_sum;
  logic [2:0]       heading_next;

  // Configuration seen at restart: saturated depth, sextant modulo six,
  // and the index of the final segment.
  always_comb begin
    depth_sat   = (cfg_depth > 4'(MAX_DEPTH)) ? 4'(MAX_DEPTH) : cfg_depth;
    sextant_mod = (cfg_sextant >= 3'd6) ? cfg_sextant - 3'd6 : cfg_sextant;
    for (int j = 0; j < IDX_W; j++) begin
      mask[j] = (j < 2 * int'(depth_sat));
    end
  end

  assign is_restart = (cmd == CMD_RESTART);
  assign last_seg   = (seg_idx == total_m1);

  // Step vector for the current heading.
  always_comb begin
    half = step_full >> 1;
    unique case (heading)
      3'd0: begin dx = step_full;        dy = '0;                end
      3'd1: begin dx = half;             dy = step_height;       end
      3'd2: begin dx = 32'd0 - half;     dy = step_height;       end
      3'd3: begin dx = 32'd0 - step_full; dy = '0;               end
      3'd4: begin dx = 32'd0 - half;     dy = 32'd0 - step_height; end
      default: begin dx = half;          dy = 32'd0 - step_height; end
    endcase
    to_x = pen_x + dx;
    to_y = pen_y + dy;
  end

  // Heading change on index increment: trailing threes roll over to
  // zero without effect, and the lowest other digit decides the turn.
  always_comb begin
    low_digit = 2'd0;
    for (int k = MAX_DEPTH - 1; k >= 0; k--) begin
      if (seg_idx[2*k +: 2] != 2'd3) begin
        low_digit = seg_idx[2*k +: 2];
      end
    end
    delta        = (low_digit == 2'd1) ? 3'd4 : 3'd1;
    head_sum     = {1'b0, heading} + {1'b0, delta};
    heading_next = (head_sum >= 4'd6) ? 3'(head_sum - 4'd6) : head_sum[2:0];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      WK_READY: begin
        if (cmd_valid && is_restart && (depth_sat != 4'd0)) begin
          state_next = WK_SETUP;
        end
      end
      WK_SETUP: if (setup_rsp.done) state_next = WK_FIRST;
      WK_FIRST: if (!out_full) state_next = WK_READY;
      default:  state_next = WK_READY;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_pop          = (state == WK_READY) && cmd_valid &&
                       (is_restart || !running || !out_full);
    do_restart       = (state == WK_READY) && cmd_valid && is_restart;
    setup_req.start  = do_restart && (depth_sat != 4'd0);
    setup_req.length = cfg_length;
    setup_req.depth  = depth_sat;
    emit             = ((state == WK_READY) && cmd_valid && !is_restart &&
                        running && !out_full) ||
                       ((state == WK_FIRST) && !out_full);
    out_push         = emit;
    out_data.from_x  = pen_x;
    out_data.from_y  = pen_y;
    out_data.to_x    = to_x;
    out_data.to_y    = to_y;
    out_data.last    = last_seg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= WK_READY;
    end else begin
      state <= state_next;
    end
  end

  // Walk control: running flag and segment index.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      seg_idx <= '0;
    end else if (do_restart) begin
      running <= (depth_sat != 4'd0);
      seg_idx <= '0;
    end else if (emit) begin
      if (last_seg) begin
        running <= 1'b0;
      end else begin
        seg_idx <= seg_idx + IDX_W'(1);
      end
    end
  end

  // Pen, heading and step vectors.
  always_ff @(posedge clk) begin
    if (setup_req.start) begin
      pen_x    <= cfg_start_x;
      pen_y    <= cfg_start_y;
      heading  <= sextant_mod;
      total_m1 <= mask;
    end else if (emit) begin
      pen_x <= to_x;
      pen_y <= to_y;
      if (!last_seg) begin
        heading <= heading_next;
      end
    end
    if ((state == WK_SETUP) && setup_rsp.done) begin
      step_full   <= setup_rsp.step_full;
      step_height <= setup_rsp.step_height;
    end
  end

`ifndef ASSERT_OFF
  a_emit_has_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> !out_full)
    else $error("segment emitted into a full result queue");

  a_no_emit_in_setup: assert property (@(posedge clk) disable iff (rst)
    (state == WK_SETUP) |-> !emit)
    else $error("segment emitted while step setup is in progress");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    running |-> (seg_idx <= total_m1))
    else $error("segment index ran past the final segment");

  a_last_stops: assert property (@(posedge clk) disable iff (rst)
    (emit && last_seg && (state == WK_READY)) |=> !running)
    else $error("walk still running after the final segment");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/koch_curve_segment_generator.sv @@
// Channel   Direction  Handshake                  Payload
// -------   ---------  -------------------------  ------------------------------
// request   in         push / full                restart
// result    out        pop / empty                from_x from_y to_x to_y last
// config    in         psel penable pwrite pready paddr pwdata prdata
//
// An advance request yields one segment per cycle while a walk is running and
// the result queue has room. Before a restart queues its first segment it passes
// through the request queue, one divide-by-three step per depth level, a square, a
// triple, the integer square root, the done state and the emit. Synchronous reset
// empties both queues and leaves the walk idle. Requests queue up to four deep
// while the walker is busy or the result queue is full; results wait in a
// two-entry queue.
`default_nettype none

module koch_curve_segment_generator
  import kcsg_pkg::*;
#(
  parameter int MAX_DEPTH = 8,
  parameter int CMD_DEPTH = 4,
  parameter int OUT_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               restart,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [31:0]      from_x,
  output logic signed [31:0]      from_y,
  output logic signed [31:0]      to_x,
  output logic signed [31:0]      to_y,
  output logic                    last,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [31:0] start_x;
  logic [31:0] start_y;
  logic [31:0] curve_length;
  logic [3:0]  curve_depth;
  logic [2:0]  start_sextant;
  logic [2:0]  reg_idx;
  logic        cfg_write;

  cmd_t                   cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_vec;
  logic                   cmd_empty;
  logic                   cmd_pop;
  setup_req_t             setup_req;
  setup_rsp_t             setup_rsp;
  logic                   out_full;
  logic                   out_push;
  result_t                walk_data;
  logic [$bits(result_t)-1:0] out_vec;
  result_t                out_data;

  // Configuration registers.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x       <= '0;
      start_y       <= '0;
      curve_length  <= '0;
      curve_depth   <= 4'd1;
      start_sextant <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_START_X:       start_x       <= pwdata;
        REG_START_Y:       start_y       <= pwdata;
        REG_CURVE_LENGTH:  curve_length  <= pwdata;
        REG_CURVE_DEPTH:   curve_depth   <= pwdata[3:0];
        REG_START_SEXTANT: start_sextant <= pwdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START_X:       prdata = start_x;
      REG_START_Y:       prdata = start_y;
      REG_CURVE_LENGTH:  prdata = curve_length;
      REG_CURVE_DEPTH:   prdata = {28'd0, curve_depth};
      REG_START_SEXTANT: prdata = {29'd0, start_sextant};
      default:           prdata = '0;
    endcase
  end

  // Front end: classify each request and queue it.
  assign cmd_in = restart ? CMD_RESTART : CMD_ADVANCE;

  kcsg_fifo #(
    .W     ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (cmd_in),
    .full    (full),
    .pop     (cmd_pop),
    .rd_data (cmd_vec),
    .empty   (cmd_empty)
  );

  // Back end: turtle walk and step setup.
  kcsg_walker #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_walker (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (!cmd_empty),
    .cmd         (cmd_t'(cmd_vec)),
    .cmd_pop     (cmd_pop),
    .cfg_start_x (start_x),
    .cfg_start_y (start_y),
    .cfg_length  (curve_length),
    .cfg_depth   (curve_depth),
    .cfg_sextant (start_sextant),
    .setup_req   (setup_req),
    .setup_rsp   (setup_rsp),
    .out_full    (out_full),
    .out_push    (out_push),
    .out_data    (walk_data)
  );

  kcsg_setup u_setup (
    .clk (clk),
    .rst (rst),
    .req (setup_req),
    .rsp (setup_rsp)
  );

  // Result queue.
  kcsg_fifo #(
    .W     ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (out_push),
    .wr_data (walk_data),
    .full    (out_full),
    .pop     (pop),
    .rd_data (out_vec),
    .empty   (empty)
  );

  assign out_data = result_t'(out_vec);
  assign from_x   = out_data.from_x;
  assign from_y   = out_data.from_y;
  assign to_x     = out_data.to_x;
  assign to_y     = out_data.to_y;
  assign last     = out_data.last;

endmodule

`default_nettype wire
